@@ design/sus_pkg.sv @@
// shared types and constants of the sorted unique set engine
// no dependencies; used by the top level and its checker
package sus_pkg;

  localparam int DEF_CAPACITY = 32;
  localparam int VAL_W        = 32;
  localparam int OP_W         = 2;
  localparam int KIND_W       = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT    = 2'd0,
    OP_DELETE    = 2'd1,
    OP_DUMP_ASC  = 2'd2,
    OP_DUMP_DESC = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ELEMENT   = 3'd0,
    KIND_EMPTY     = 3'd1,
    KIND_INSERTED  = 3'd2,
    KIND_DUPLICATE = 3'd3,
    KIND_FULL      = 3'd4,
    KIND_DELETED   = 3'd5,
    KIND_NOT_FOUND = 3'd6
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_INS_RD,
    ST_INS_WR,
    ST_INS_PUT,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_DEL_FIN,
    ST_STAT,
    ST_DUMP_RD,
    ST_DUMP_LD
  } state_t;

endpackage

@@ design/sorted_unique_set_engine_unit.sv @@
// top level of the sorted unique set engine: sequencer, value memory, output register
// depends on sus_pkg
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tuser = op, s_tdata = value
//  m_      | out | m_tvalid/m_tready  | m_tuser = kind, m_tdata = element, m_tlast = last
//
// one item is worked at a time by a single signed comparator over a memory with one write port and one read port
// insert/delete: after the item is accepted, a lower-bound walk reads then compares each
//   entry below the operand, then each entry to be shifted is read then written one place
//   over, then the status result is loaded
// dumps: each stored value is read, then loaded to the output; an empty dump loads one EMPTY result
// rst is synchronous; it empties the set and drops any pending result, no clearing pass
// a stalled m_ side holds the block only when a new result must be loaded; the last
//   result of an item may wait in the output register while the next item is taken
module sorted_unique_set_engine_unit #(
  parameter int CAPACITY = sus_pkg::DEF_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [sus_pkg::VAL_W-1:0]   s_tdata,   // [31:0] value
  input  logic [sus_pkg::OP_W-1:0]    s_tuser,   // [1:0] op
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [sus_pkg::VAL_W-1:0]   m_tdata,   // [31:0] element
  output logic [sus_pkg::KIND_W-1:0]  m_tuser,   // [2:0] kind
  output logic                        m_tlast
);

  // count holds 0..CAPACITY, address holds 0..CAPACITY-1
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  sus_pkg::state_t state, state_next;
  sus_pkg::op_t    opc, opc_next;
  sus_pkg::kind_t  res_kind, res_next;

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] pos, pos_next;
  logic [CW-1:0] idx_inc, idx_dec;
  logic signed [sus_pkg::VAL_W-1:0] opv, opv_next;

  // value memory, read data registered
  logic signed [sus_pkg::VAL_W-1:0] mem [CAPACITY];
  logic signed [sus_pkg::VAL_W-1:0] rd_data;
  logic                             mem_we;
  logic [AW-1:0]                    mem_wa;
  logic signed [sus_pkg::VAL_W-1:0] mem_wd;

  // shared comparator
  logic cmp_lt, cmp_eq;

  // search outcome
  logic srch_done, srch_hit;

  // output load
  logic                             out_free;
  logic                             load;
  sus_pkg::kind_t                   load_kind;
  logic [sus_pkg::VAL_W-1:0]        load_elem;
  logic                             load_last;
  logic                             dump_last;

  assign cmp_lt   = rd_data < opv;
  assign cmp_eq   = rd_data == opv;
  assign idx_inc  = idx + CW'(1);
  assign idx_dec  = idx - CW'(1);
  assign out_free = !m_tvalid || m_tready;
  assign dump_last = (opc == sus_pkg::OP_DUMP_ASC) ? (idx == count - CW'(1))
                                                   : (idx == '0);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sus_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // working registers carry no reset
  always_ff @(posedge clk) begin
    opc      <= opc_next;
    opv      <= opv_next;
    idx      <= idx_next;
    pos      <= pos_next;
    res_kind <= res_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tuser <= load_kind;
      m_tdata <= load_elem;
      m_tlast <= load_last;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    pos_next   = pos;
    opc_next   = opc;
    opv_next   = opv;
    res_next   = res_kind;
    mem_we     = 1'b0;
    mem_wa     = idx[AW-1:0];
    mem_wd     = rd_data;
    load       = 1'b0;
    load_kind  = sus_pkg::KIND_ELEMENT;
    load_elem  = rd_data;
    load_last  = 1'b0;
    srch_done  = 1'b0;
    srch_hit   = 1'b0;
    s_tready   = (state == sus_pkg::ST_IDLE);

    case (state)
      sus_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          opc_next = sus_pkg::op_t'(s_tuser);
          opv_next = s_tdata;
          idx_next = '0;
          if (s_tuser == sus_pkg::OP_INSERT || s_tuser == sus_pkg::OP_DELETE) begin
            state_next = sus_pkg::ST_SRCH_RD;
          end else if (count == '0) begin
            res_next   = sus_pkg::KIND_EMPTY;
            state_next = sus_pkg::ST_STAT;
          end else begin
            idx_next   = (s_tuser == sus_pkg::OP_DUMP_ASC) ? '0 : count - CW'(1);
            state_next = sus_pkg::ST_DUMP_RD;
          end
        end
      end

      // lower bound walk: read entry idx, compare on the next cycle
      sus_pkg::ST_SRCH_RD: begin
        if (idx == count) begin
          srch_done = 1'b1;
        end else begin
          state_next = sus_pkg::ST_SRCH_CMP;
        end
      end

      sus_pkg::ST_SRCH_CMP: begin
        if (cmp_lt) begin
          idx_next   = idx_inc;
          state_next = sus_pkg::ST_SRCH_RD;
        end else begin
          srch_done = 1'b1;
          srch_hit  = cmp_eq;
        end
      end

      // insert: move entries pos..count-1 up by one, top first
      sus_pkg::ST_INS_RD: begin
        state_next = sus_pkg::ST_INS_WR;
      end

      sus_pkg::ST_INS_WR: begin
        mem_we = 1'b1;
        mem_wa = idx_inc[AW-1:0];
        if (idx == pos) begin
          state_next = sus_pkg::ST_INS_PUT;
        end else begin
          idx_next   = idx_dec;
          state_next = sus_pkg::ST_INS_RD;
        end
      end

      sus_pkg::ST_INS_PUT: begin
        mem_we     = 1'b1;
        mem_wa     = pos[AW-1:0];
        mem_wd     = opv;
        count_next = count + CW'(1);
        res_next   = sus_pkg::KIND_INSERTED;
        state_next = sus_pkg::ST_STAT;
      end

      // delete: move entries pos+1..count-1 down by one
      sus_pkg::ST_DEL_RD: begin
        state_next = sus_pkg::ST_DEL_WR;
      end

      sus_pkg::ST_DEL_WR: begin
        mem_we = 1'b1;
        mem_wa = idx_dec[AW-1:0];
        if (idx_inc == count) begin
          state_next = sus_pkg::ST_DEL_FIN;
        end else begin
          idx_next   = idx_inc;
          state_next = sus_pkg::ST_DEL_RD;
        end
      end

      sus_pkg::ST_DEL_FIN: begin
        count_next = count - CW'(1);
        res_next   = sus_pkg::KIND_DELETED;
        state_next = sus_pkg::ST_STAT;
      end

      // single status result, element is the operand (zero for an empty dump)
      sus_pkg::ST_STAT: begin
        if (out_free) begin
          load       = 1'b1;
          load_kind  = res_kind;
          load_elem  = (res_kind == sus_pkg::KIND_EMPTY) ? '0 : opv;
          load_last  = 1'b1;
          state_next = sus_pkg::ST_IDLE;
        end
      end

      sus_pkg::ST_DUMP_RD: begin
        state_next = sus_pkg::ST_DUMP_LD;
      end

      // rd_data keeps following idx, so a stall here is harmless
      sus_pkg::ST_DUMP_LD: begin
        if (out_free) begin
          load      = 1'b1;
          load_kind = sus_pkg::KIND_ELEMENT;
          load_elem = rd_data;
          load_last = dump_last;
          if (dump_last) begin
            state_next = sus_pkg::ST_IDLE;
          end else begin
            idx_next   = (opc == sus_pkg::OP_DUMP_ASC) ? idx_inc : idx_dec;
            state_next = sus_pkg::ST_DUMP_RD;
          end
        end
      end

      default: begin
        state_next = sus_pkg::ST_IDLE;
      end
    endcase

    // search finished: idx is the lower bound
    if (srch_done) begin
      pos_next = idx;
      if (opc == sus_pkg::OP_INSERT) begin
        if (srch_hit) begin
          res_next   = sus_pkg::KIND_DUPLICATE;
          state_next = sus_pkg::ST_STAT;
        end else if (count == CW'(CAPACITY)) begin
          res_next   = sus_pkg::KIND_FULL;
          state_next = sus_pkg::ST_STAT;
        end else if (idx == count) begin
          state_next = sus_pkg::ST_INS_PUT;
        end else begin
          idx_next   = count - CW'(1);
          state_next = sus_pkg::ST_INS_RD;
        end
      end else begin
        if (!srch_hit) begin
          res_next   = sus_pkg::KIND_NOT_FOUND;
          state_next = sus_pkg::ST_STAT;
        end else if (idx_inc == count) begin
          state_next = sus_pkg::ST_DEL_FIN;
        end else begin
          idx_next   = idx_inc;
          state_next = sus_pkg::ST_DEL_RD;
        end
      end
    end
  end

endmodule

@@ design/sus_checker.sv @@
// port-level checker of the sorted unique set engine, with its bind
// depends on sus_pkg and sorted_unique_set_engine_unit
module sus_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [sus_pkg::VAL_W-1:0]   m_tdata,
  input logic [sus_pkg::KIND_W-1:0]  m_tuser,
  input logic                        m_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  // status results always close their item
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != sus_pkg::KIND_ELEMENT |-> m_tlast)
    else $error("status result without last");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= sus_pkg::KIND_NOT_FOUND)
    else $error("undefined result kind");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == sus_pkg::KIND_EMPTY |-> m_tdata == '0)
    else $error("empty-set result with nonzero element");

  a_rst_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending after reset");

endmodule

bind sorted_unique_set_engine_unit sus_checker u_sus_checker (.*);
